>>> rtl/core/db_step_to_linear_gain_top_assert.svh
// Assertion macros for the volume step to linear gain block.
// Included by the top level; no other dependencies.
`ifndef DB_STEP_TO_LINEAR_GAIN_TOP_ASSERT_SVH
`define DB_STEP_TO_LINEAR_GAIN_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define DBLG_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Condition a implies condition b in the next cycle.
`define DBLG_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define DBLG_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define DBLG_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif

`endif

>>> rtl/core/dblg_pkg.sv
// Shared types, constants and the rounding Q16 multiply for the gain block.
// No dependencies.
package dblg_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 10;
  localparam int GAIN_W      = 31;
  localparam int MIN_W       = 15;
  localparam int STEPDB_W    = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [16:0] ROOT20_TEN = 17'd73533;
  localparam logic [16:0] ROOT40_TEN = 17'd69419;
  localparam logic [31:0] Q16_ONE    = 32'd65536;
  localparam logic [31:0] U32_SAT    = 32'hffff_ffff;
  localparam logic [GAIN_W-1:0] Q31_MAX = 31'h7fff_ffff;
  localparam logic [14:0] HALF_DB_CENTI = 15'd50;
  localparam logic [32:0] INV_DIVIDEND = 33'h1_0000_0000;

  // x / 100 == (x * 5243) >> 19 for every x below 43699.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // x / 100 == (x * 42949673) >> 32 for every x below 2^30.
  localparam logic [25:0] SUM_RECIP = 26'd42949673;
  localparam int          SUM_SHIFT = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE    = 2'd2;

  typedef struct packed {
    logic signed [MIN_W-1:0] min_centi_db;
    logic [STEPDB_W-1:0]     step_centi_db;
    logic                    mute_at_zero;
  } dblg_cfg_t;

  localparam dblg_cfg_t CFG_RESET = '{
    min_centi_db:  -15'sd9000,
    step_centi_db: 14'd50,
    mute_at_zero:  1'b1
  };

  typedef struct packed {
    logic load_idx;
    logic prep;
    logic sum_start;
    logic sum_load;
    logic pow_step;
    logic inv_start;
    logic inv_load;
    logic frac_step;
    logic out_load;
  } dblg_cmd_t;

  typedef struct packed {
    logic mute;
    logic div_busy;
    logic div_done;
    logic pow_done;
    logic neg;
    logic half;
  } dblg_sts_t;

  // Rounding multiply of unsigned Q16 values, saturated at 32 bits.
  function automatic logic [31:0] qmul(input logic [31:0] x, input logic [16:0] y);
    logic [48:0] prod;
    logic [32:0] rnd;
    prod = {17'd0, x} * {32'd0, y};
    prod = prod + (49'd1 << (FRAC_BITS - 1));
    rnd  = prod[48:FRAC_BITS];
    return rnd[32] ? U32_SAT : rnd[31:0];
  endfunction

endpackage

>>> rtl/core/dblg_if.sv
// Valid/ready channel interfaces for the gain block: input, result, config.
// Depends on dblg_pkg for field widths.
interface dblg_in_if import dblg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_index;
  modport source (output valid, output step_index, input ready);
  modport sink (input valid, input step_index, output ready);
endinterface

interface dblg_out_if import dblg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain_q31;
  modport source (output valid, output gain_q31, input ready);
  modport sink (input valid, input gain_q31, output ready);
endinterface

interface dblg_cfg_if import dblg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/dblg_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 32-bit divisor.
// Depends on dblg_pkg.
module dblg_div import dblg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [32:0] quotient
);

  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [32:0]      quo_r, quo_nxt;
  logic [31:0]      dvs_r, dvs_nxt;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             take;

  always_comb begin
    trial    = {rem_r, quo_r[32]};
    diff     = trial - {1'b0, dvs_r};
    take     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = take ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[31:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/dblg_dp.sv
// Datapath: dB sum, power loop register, inversion through the divider, Q31 output.
// Depends on dblg_pkg and dblg_div.
module dblg_dp import dblg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dblg_cfg_t         cfg,
  input  dblg_cmd_t         cmd,
  input  logic [STEP_W-1:0] in_step_index,
  output dblg_sts_t         sts,
  output logic [GAIN_W-1:0] gain_q31
);

  logic [STEP_W-1:0] idx_r;
  logic [7:0]        minq_r;
  logic              min_neg_r;
  logic [7:0]        stepq_r;
  logic [23:0]       prod_r;
  logic [17:0]       sumq_r;
  logic              half_r;
  logic              neg_r;
  logic [17:0]       cnt_r;
  logic [31:0]       p_r;
  logic [GAIN_W-1:0] gain_r;

  logic [14:0]        min_mag;
  logic [27:0]        min_prod;
  logic [26:0]        step_prod;
  logic [23:0]        idx_prod;
  logic [49:0]        sum_prod;
  logic [14:0]        step_rem;
  logic signed [18:0] minq_s;
  logic signed [18:0] db;
  logic signed [18:0] db_neg;
  logic [17:0]        db_mag;
  logic               div_start;
  logic [32:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [32:0]        div_quo;

  always_comb begin
    min_mag   = cfg.min_centi_db[MIN_W-1] ? $unsigned(~cfg.min_centi_db + 15'sd1)
                                          : $unsigned(cfg.min_centi_db);
    min_prod  = {13'd0, min_mag} * {15'd0, RECIP_100};
    step_prod = {13'd0, cfg.step_centi_db} * {14'd0, RECIP_100};
    idx_prod  = {14'd0, idx_r} * {10'd0, cfg.step_centi_db};
    sum_prod  = {26'd0, prod_r} * {24'd0, SUM_RECIP};
    step_rem  = {1'b0, cfg.step_centi_db} - ({7'd0, stepq_r} * 15'd100);
    minq_s    = min_neg_r ? -$signed({11'd0, minq_r}) : $signed({11'd0, minq_r});
    db        = minq_s + $signed({1'b0, sumq_r});
    db_neg    = -db;
    db_mag    = db[18] ? db_neg[17:0] : db[17:0];
  end

  assign div_start    = cmd.inv_start;
  assign div_dividend = INV_DIVIDEND;
  assign div_divisor  = p_r;

  dblg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_idx) begin
      idx_r <= in_step_index;
    end
    if (cmd.prep) begin
      minq_r    <= min_prod[RECIP_SHIFT +: 8];
      min_neg_r <= cfg.min_centi_db[MIN_W-1];
      stepq_r   <= step_prod[RECIP_SHIFT +: 8];
      prod_r    <= idx_prod;
    end
    if (cmd.sum_start) begin
      sumq_r <= sum_prod[SUM_SHIFT +: 18];
      half_r <= (step_rem == HALF_DB_CENTI) && idx_r[0];
    end
    if (cmd.sum_load) begin
      neg_r <= db[18];
      cnt_r <= db_mag;
      p_r   <= Q16_ONE;
    end else if (cmd.pow_step) begin
      cnt_r <= cnt_r - 18'd1;
      p_r   <= qmul(p_r, ROOT20_TEN);
    end else if (cmd.inv_load) begin
      p_r <= div_quo[31:0];
    end else if (cmd.frac_step) begin
      p_r <= qmul(p_r, ROOT40_TEN);
    end
    if (cmd.out_load) begin
      if (sts.mute) begin
        gain_r <= '0;
      end else if (p_r[31:FRAC_BITS] != '0) begin
        gain_r <= Q31_MAX;
      end else begin
        gain_r <= {p_r[FRAC_BITS-1:0], 15'd0};
      end
    end
  end

  always_comb begin
    sts.mute     = (idx_r == '0) && cfg.mute_at_zero;
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.pow_done = (cnt_r == '0) || (p_r == U32_SAT);
    sts.neg      = neg_r;
    sts.half     = half_r;
  end

  assign gain_q31 = gain_r;

endmodule

>>> rtl/core/dblg_ctrl.sv
// Controller state machine: sequences one step index through the datapath.
// Depends on dblg_pkg; drives the datapath only through command and status.
module dblg_ctrl import dblg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dblg_sts_t sts,
  output dblg_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PREP     = 9'b000000010,
    S_SUM      = 9'b000000100,
    S_SUM_WAIT = 9'b000001000,
    S_POW      = 9'b000010000,
    S_INV      = 9'b000100000,
    S_INV_WAIT = 9'b001000000,
    S_FRAC     = 9'b010000000,
    S_FINAL    = 9'b100000000
  } dblg_state_t;

  dblg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_idx = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.mute ? S_FINAL : S_SUM;
      end
      S_SUM: begin
        cmd.sum_start = 1'b1;
        state_nxt     = S_SUM_WAIT;
      end
      S_SUM_WAIT: begin
        // The scaled step quotient was registered in the previous cycle.
        cmd.sum_load = 1'b1;
        state_nxt    = S_POW;
      end
      S_POW: begin
        if (!sts.pow_done) begin
          cmd.pow_step = 1'b1;
        end else begin
          state_nxt = sts.neg ? S_INV : S_FRAC;
        end
      end
      S_INV: begin
        cmd.inv_start = 1'b1;
        state_nxt     = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (sts.div_done) begin
          cmd.inv_load = 1'b1;
          state_nxt    = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.frac_step = sts.half;
        state_nxt     = S_FINAL;
      end
      S_FINAL: begin
        // The result register is free or is emptied in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/db_step_to_linear_gain_top.sv
// Top level of the volume step to linear gain block: config registers,
// controller and datapath. Depends on dblg_pkg, dblg_if, dblg_ctrl, dblg_dp.
//
//   channel  | direction | payload                     | handshake
//   ---------+-----------+-----------------------------+-------------
//   in_ch    | sink      | step_index[9:0]             | valid/ready
//   out_ch   | source    | gain_q31[30:0]              | valid/ready
//   cfg_ch   | sink      | index[1:0], data[14:0]      | valid/ready
//
// One item at a time: a step index is accepted in IDLE and the input is ready again
// only after FINAL loads the result, which waits while the output register is full.
// A muted step zero skips from PREP to FINAL; else the power loop does one rounding
// multiply per cycle, at most 97 before saturation; a negative power adds the 33-step divider.
// Reset is synchronous and active low; no clearing pass is needed.
// A new item is taken while the previous result still waits in the output register.
`include "db_step_to_linear_gain_top_assert.svh"
module db_step_to_linear_gain_top import dblg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dblg_in_if.sink    in_ch,
  dblg_out_if.source out_ch,
  dblg_cfg_if.sink   cfg_ch
);

  dblg_cfg_t cfg_r, cfg_nxt;
  dblg_cmd_t cmd;
  dblg_sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MIN_DB:  cfg_nxt.min_centi_db  = $signed(cfg_ch.data[MIN_W-1:0]);
        CFG_STEP_DB: cfg_nxt.step_centi_db = cfg_ch.data[STEPDB_W-1:0];
        CFG_MUTE:    cfg_nxt.mute_at_zero  = cfg_ch.data[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  dblg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dblg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .in_step_index (in_ch.step_index),
    .sts           (sts),
    .gain_q31      (out_ch.gain_q31)
  );

  `DBLG_ASSERT_NXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while an item is in flight")
  `DBLG_ASSERT_IMP(a_div_free, clk, rst_n, cmd.inv_start, !sts.div_busy, "divider restarted while busy")
  `DBLG_ASSERT_NXT(a_out_valid, clk, rst_n, cmd.out_load, out_ch.valid, "loaded result not presented")
  `DBLG_ASSERT_NXT(a_mute_zero, clk, rst_n, cmd.out_load && sts.mute, out_ch.gain_q31 == '0, "muted step gave nonzero gain")

endmodule

>>> test/db_step_to_linear_gain_top_test.sv
// Self-checking testbench for the volume step to linear gain block.
// Depends on dblg_pkg, the dblg_if channel interfaces and db_step_to_linear_gain_top.
`timescale 1ns / 100ps
module db_step_to_linear_gain_top_test;
  import dblg_pkg::*;

  localparam int IDLE_PCT      = 11;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int RAND_PHASES   = 8;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One row of the directed part: the register setting, the step and, where it is
  // obvious, the gain that must come back.
  typedef struct packed {
    logic [MIN_W-1:0]    min_bits;
    logic [STEPDB_W-1:0] step_bits;
    logic                mute;
    logic [STEP_W-1:0]   step_index;
    logic                typed;
    logic [GAIN_W-1:0]   gain;
  } step_row_t;

  typedef struct packed {
    logic              typed;
    logic [GAIN_W-1:0] gain;
  } typed_gain_t;

  localparam int NUM_ROWS = 21;
  step_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{-9000, 50, 1'b1, 0, 1'b1, 0},
    '{-9000, 50, 1'b1, 1, 1'b0, 0},
    '{-9000, 50, 1'b1, 180, 1'b1, Q31_MAX},
    '{-9000, 50, 1'b1, 181, 1'b1, Q31_MAX},
    '{-9000, 50, 1'b1, 1023, 1'b1, Q31_MAX},
    '{-9000, 50, 1'b1, 2, 1'b0, 0},
    '{-9000, 50, 1'b0, 0, 1'b0, 0},
    '{-16384, 0, 1'b0, 0, 1'b1, 32768},
    '{16383, 0, 1'b0, 0, 1'b1, Q31_MAX},
    '{-16384, 16383, 1'b0, 1023, 1'b1, Q31_MAX},
    '{16383, 16383, 1'b1, 1023, 1'b1, Q31_MAX},
    '{-99, 0, 1'b0, 5, 1'b1, Q31_MAX},
    '{-100, 0, 1'b0, 7, 1'b0, 0},
    '{-12800, 150, 1'b1, 3, 1'b0, 0},
    '{-12800, 150, 1'b1, 2, 1'b0, 0},
    '{-12800, 150, 1'b1, 0, 1'b1, 0},
    '{12800, 10000, 1'b0, 1, 1'b1, Q31_MAX},
    '{-16384, 50, 1'b1, 1, 1'b1, 32768},
    '{-4800, 0, 1'b0, 9, 1'b0, 0},
    '{-2000, 250, 1'b0, 1, 1'b0, 0},
    '{-2000, 16383, 1'b0, 1, 1'b0, 0}
  };

  logic clk;
  logic rst_n;

  dblg_in_if  in_ch();
  dblg_out_if out_ch();
  dblg_cfg_if cfg_ch();

  db_step_to_linear_gain_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register copies seen by the gain predictor, updated on each config transaction.
  int   model_min_cdb  = -9000;
  int   model_step_cdb = 50;
  logic model_mute     = 1'b1;

  // Setting last programmed by the stimulus side.
  logic [MIN_W-1:0]    cur_min  = 15'h5cd8;
  logic [STEPDB_W-1:0] cur_step = 14'd50;
  logic                cur_mute = 1'b1;

  logic [GAIN_W-1:0] gain_expect [$];
  typed_gain_t       typed_gain [$];
  int                items_sent   = 0;
  int                results_seen = 0;
  int                mismatches   = 0;
  int                cycle_count  = 0;
  bit                calm         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] round_mul_q16(input logic [31:0] x, input logic [16:0] y);
    logic [63:0] prod;
    prod = {32'd0, x} * {47'd0, y};
    prod = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (prod > {32'd0, U32_SAT}) ? U32_SAT : prod[31:0];
  endfunction

  function automatic logic [GAIN_W-1:0] predict_gain(input logic [STEP_W-1:0] idx);
    int          db;
    int unsigned mag;
    logic [31:0] g;
    logic [63:0] wide;
    if (idx == '0 && model_mute)
      return '0;
    // Both divisions truncate toward zero, the first one on a signed value.
    db = model_min_cdb / 100 + (int'(idx) * model_step_cdb) / 100;
    mag = (db < 0) ? -db : db;
    g = Q16_ONE;
    for (int unsigned k = 0; k < mag && g != U32_SAT; k++)
      g = round_mul_q16(g, ROOT20_TEN);
    if (db < 0) begin
      wide = 64'h1_0000_0000 / {32'd0, g};
      g = wide[31:0];
    end
    if (model_step_cdb % 100 == int'(HALF_DB_CENTI) && idx[0])
      g = round_mul_q16(g, ROOT40_TEN);
    wide = {32'd0, g} << 15;
    return (wide > {33'd0, Q31_MAX}) ? Q31_MAX : wide[GAIN_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [GAIN_W-1:0] got,
                                 input logic [GAIN_W-1:0] want);
    $display("[%0t] mismatch: %s: gain_q31 got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  // Monitor: configuration shadow, expectations and result checks.
  typed_gain_t       tg;
  logic [GAIN_W-1:0] want;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MIN_DB:  model_min_cdb = $signed(cfg_ch.data);
          CFG_STEP_DB: model_step_cdb = int'(cfg_ch.data[STEPDB_W-1:0]);
          CFG_MUTE:    model_mute = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = predict_gain(in_ch.step_index);
        if (typed_gain.size() > 0) begin
          tg = typed_gain.pop_front();
          if (tg.typed)
            want = tg.gain;
        end
        gain_expect.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (gain_expect.size() == 0) begin
          report_mismatch("result with nothing pending", out_ch.gain_q31, '0);
        end else begin
          want = gain_expect.pop_front();
          if (out_ch.gain_q31 !== want)
            report_mismatch("wrong gain", out_ch.gain_q31, want);
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_step(input logic [STEP_W-1:0] idx, input logic typed,
                           input logic [GAIN_W-1:0] gain);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    typed_gain.push_back('{typed, gain});
    in_ch.valid      <= 1'b1;
    in_ch.step_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Unused register bits carry random values; they must not matter.
  task automatic program_gain(input logic [MIN_W-1:0] min_bits,
                              input logic [STEPDB_W-1:0] step_bits,
                              input logic mute, input bit spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if (spare)
      cfg_write(CFG_SPARE, junk);
    cfg_write(CFG_MIN_DB, min_bits);
    cfg_write(CFG_STEP_DB, {junk[0], step_bits});
    cfg_write(CFG_MUTE, {junk[14:1], mute});
    cfg_ch.valid <= 1'b0;
    cur_min  = min_bits;
    cur_step = step_bits;
    cur_mute = mute;
  endtask

  initial begin
    step_row_t           row;
    int                  v;
    int                  count;
    int                  pick;
    logic [MIN_W-1:0]    rmin;
    logic [STEPDB_W-1:0] rstep;
    logic [STEP_W-1:0]   ridx;
    bit                  first_write;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.step_index = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    first_write      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the reset setting without any register write.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      if (row.min_bits != cur_min || row.step_bits != cur_step || row.mute != cur_mute) begin
        wait_all_results();
        program_gain(row.min_bits, row.step_bits, row.mute, first_write);
        first_write = 1'b0;
      end
      send_step(row.step_index, row.typed, row.gain);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_all_results();
      calm = (ph == 3);
      if (ph == 0) begin
        program_gain(-15'sd12800, 14'd50, 1'b1, 1'b0);
      end else if (ph == 1) begin
        program_gain(15'sd12800, 14'd10000, 1'b0, 1'b1);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          rmin = MIN_W'($urandom);
        end else begin
          v = -int'($urandom_range(0, 12800));
          rmin = v[MIN_W-1:0];
        end
        // Mostly small steps up to 300 centi-dB, half of these drawn as multiples of half a dB.
        if ($urandom_range(0, 4) == 0)
          rstep = STEPDB_W'($urandom_range(0, 16383));
        else if ($urandom_range(0, 1) == 0)
          rstep = STEPDB_W'($urandom_range(0, 6) * 50);
        else
          rstep = STEPDB_W'($urandom_range(0, 300));
        program_gain(rmin, rstep, 1'($urandom), $urandom_range(0, 3) == 0);
      end
      count = (ph == 1) ? 40 : 130;
      for (int n = 0; n < count; n++) begin
        if (ph == 5 && n == count / 2)
          wait_all_results();
        pick = $urandom_range(0, 19);
        if (pick == 0)
          ridx = '0;
        else if (pick == 1)
          ridx = '1;
        else
          ridx = STEP_W'($urandom_range(0, 1023));
        send_step(ridx, 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (gain_expect.size() > 0)
      report_mismatch("result never arrived", '0, gain_expect.pop_front());
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
